// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared sizes, request and status codes, and bundle types of the deque
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] fill;
        logic             pop_ok;
    } rsp_t;

endpackage

// File: design/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue in a ring buffer memory
//
// One request per transaction: push front, push back, pop front or pop back,
// selected by s_tuser. Every request gives exactly one result transaction in the
// cycle after it is taken, carrying the popped value, a status and the fill
// count after the request. The unit takes one request per cycle; the result
// register is the only buffer, so a result that is not taken holds off new
// requests. Pointer and count update at accept, and the memory read for a pop
// is issued in the same cycle, so the read data register feeds the result.
// A pop from an empty queue returns zero with the empty status, and a push
// to a full queue is dropped with the full status.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pop_value, fill_count, zero pad
    output logic [1:0]  m_tuser    // status
);
    import deq_pkg::*;

    logic                  accept;
    mem_req_t              mem_req;
    rsp_t                  rsp;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]           push_wide;
    logic [63:0]           rd_wide;
    logic [31:0]           pop_value;
    logic [DATA_WIDTH-1:0] push_data;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            status_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic                  pop_ok_reg;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign push_wide = {32'd0, s_tdata};
    assign push_data = push_wide[DATA_WIDTH-1:0];

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (s_tuser),
        .push_data (push_data),
        .mem_req   (mem_req),
        .rsp       (rsp)
    );

    deq_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign out_valid_next = accept || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= rsp.status;
            fill_reg   <= rsp.fill;
            pop_ok_reg <= rsp.pop_ok;
        end
    end

    assign rd_wide   = 64'(rd_data);
    assign pop_value = pop_ok_reg ? rd_wide[31:0] : 32'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, fill_reg[4:0], pop_value};
    assign m_tuser  = status_reg;

`ifndef SYNTHESIS
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> fill_reg == '0)
        else $error("empty status with nonzero fill");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> fill_reg == DEPTH_CNT)
        else $error("full status with queue not full");

    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pop_ok_reg |-> m_tuser == ST_DONE)
        else $error("popped value with error status");
`endif

endmodule

// File: design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// ring storage, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module deq_ram (
    input  logic                               clk,
    input  deq_pkg::mem_req_t                  req,
    output logic [deq_pkg::DATA_WIDTH-1:0]     rd_data
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// front pointer and entry count, ring address generation and status
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [1:0]                     req_type,
    input  logic [deq_pkg::DATA_WIDTH-1:0] push_data,
    output deq_pkg::mem_req_t              mem_req,
    output deq_pkg::rsp_t                  rsp
);
    import deq_pkg::*;

    logic [ADDR_W-1:0] front_reg;
    logic [ADDR_W-1:0] front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [SUM_W-1:0]  back_sum;
    logic [SUM_W-1:0]  last_sum;
    logic [ADDR_W-1:0] back_slot;
    logic [ADDR_W-1:0] last_slot;
    logic [ADDR_W-1:0] front_dec;
    logic [ADDR_W-1:0] front_inc;
    logic              is_full;
    logic              is_empty;

    assign is_full  = (count_reg == DEPTH_CNT);
    assign is_empty = (count_reg == '0);

    // tail slot for a push back, last held slot for a pop back
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - SUM_W'(1);
    assign back_slot = (back_sum >= DEPTH_SUM) ? ADDR_W'(back_sum - DEPTH_SUM)
                                               : ADDR_W'(back_sum);
    assign last_slot = (last_sum >= DEPTH_SUM) ? ADDR_W'(last_sum - DEPTH_SUM)
                                               : ADDR_W'(last_sum);
    assign front_dec = (front_reg == '0) ? LAST_ADDR : front_reg - ADDR_W'(1);
    assign front_inc = (front_reg == LAST_ADDR) ? '0 : front_reg + ADDR_W'(1);

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.addr    = front_reg;
        mem_req.wr_data = push_data;
        rsp.status      = ST_DONE;
        rsp.pop_ok      = 1'b0;
        unique case (req_type)
            REQ_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    mem_req.wr_en = accept;
                    mem_req.addr  = front_dec;
                    front_next    = front_dec;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK:
            begin
                if (is_full)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    mem_req.wr_en = accept;
                    mem_req.addr  = back_slot;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (is_empty)
                begin
                    rsp.status = ST_EMPTY;
                end
                else
                begin
                    mem_req.rd_en = accept;
                    mem_req.addr  = front_reg;
                    rsp.pop_ok    = 1'b1;
                    front_next    = front_inc;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (is_empty)
                begin
                    rsp.status = ST_EMPTY;
                end
                else
                begin
                    mem_req.rd_en = accept;
                    mem_req.addr  = last_slot;
                    rsp.pop_ok    = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                rsp.status = ST_DONE;
            end
        endcase
        rsp.fill = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(front_reg) < DEPTH_SUM)
        else $error("front pointer out of ring");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK) && !is_full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the queue");

    a_no_access_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.status != ST_DONE) |-> !mem_req.wr_en && !mem_req.rd_en)
        else $error("memory access on a rejected request");
`endif

endmodule

// File: tb/double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// self-checking bench for the bounded double-ended queue: a queued driver
// issues push and pop requests, a local deque tracker predicts each result,
// and a monitor compares every result transaction field by field, with
// random idle cycles on both sides
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

    import deq_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1250;
    localparam int CALM_START  = 1200;
    localparam int CALM_END    = 1800;

    typedef struct {
        logic [1:0]            kind;
        logic [DATA_WIDTH-1:0] value;
        logic                  drain;
    } req_item_t;

    typedef struct {
        logic [DATA_WIDTH-1:0] pop_value;
        logic [1:0]            status;
        logic [CNT_W-1:0]      fill_count;
    } reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = REQ_PUSH_FRONT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    req_item_t request_queue[$];
    reply_t    expected_replies[$];
    req_item_t cur_req;

    logic [DATA_WIDTH-1:0] slots[DEPTH];
    int                    head_idx  = 0;
    int                    held      = 0;
    int                    errors    = 0;
    int                    cycle_cnt = 0;

    double_ended_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic reply_t apply_request(req_item_t r);
        reply_t rep;
        rep.pop_value = '0;
        rep.status    = ST_DONE;
        if (r.kind == REQ_PUSH_FRONT || r.kind == REQ_PUSH_BACK)
        begin
            if (held >= DEPTH)
                rep.status = ST_FULL;
            else if (r.kind == REQ_PUSH_FRONT)
            begin
                head_idx        = (head_idx + DEPTH - 1) % DEPTH;
                slots[head_idx] = r.value;
                held++;
            end
            else
            begin
                slots[(head_idx + held) % DEPTH] = r.value;
                held++;
            end
        end
        else
        begin
            if (held == 0)
                rep.status = ST_EMPTY;
            else if (r.kind == REQ_POP_FRONT)
            begin
                rep.pop_value = slots[head_idx];
                head_idx      = (head_idx + 1) % DEPTH;
                held--;
            end
            else
            begin
                rep.pop_value = slots[(head_idx + held - 1) % DEPTH];
                held--;
            end
        end
        rep.fill_count = CNT_W'(held);
        return rep;
    endfunction

    function automatic logic calm_window();
        return cycle_cnt >= CALM_START && cycle_cnt < CALM_END;
    endfunction

    task automatic add_req(logic [1:0] kind, logic [DATA_WIDTH-1:0] value, logic drain);
        req_item_t r;
        r.kind  = kind;
        r.value = value;
        r.drain = drain;
        request_queue.push_back(r);
    endtask

    // request driver
    always @(posedge clk)
    begin : driver
        logic next_valid;
        logic fire;
        fire       = s_tvalid && s_tready;
        next_valid = s_tvalid;
        if (!rst_n)
            next_valid = 1'b0;
        else
        begin
            if (fire)
                expected_replies.push_back(apply_request(cur_req));
            if (!s_tvalid || fire)
            begin
                next_valid = 1'b0;
                if (request_queue.size() != 0
                    && (calm_window() || $urandom_range(99) >= 15)
                    && !(request_queue[0].drain && expected_replies.size() != 0))
                begin
                    cur_req    = request_queue.pop_front();
                    next_valid = 1'b1;
                    s_tdata   <= cur_req.value;
                    s_tuser   <= cur_req.kind;
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // result monitor
    always @(posedge clk)
    begin : monitor
        reply_t exp_rep;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                errors++;
            end
            else
            begin
                exp_rep = expected_replies.pop_front();
                if (m_tdata[DATA_WIDTH-1:0] !== exp_rep.pop_value)
                begin
                    $error("pop_value expected %h got %h",
                           exp_rep.pop_value, m_tdata[DATA_WIDTH-1:0]);
                    errors++;
                end
                if (m_tuser !== exp_rep.status)
                begin
                    $error("status expected %0d got %0d", exp_rep.status, m_tuser);
                    errors++;
                end
                if (m_tdata[DATA_WIDTH +: CNT_W] !== exp_rep.fill_count)
                begin
                    $error("fill_count expected %0d got %0d",
                           exp_rep.fill_count, m_tdata[DATA_WIDTH +: CNT_W]);
                    errors++;
                end
            end
        end
        m_tready <= calm_window() || $urandom_range(99) >= 15;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int total;
        int mode;
        int run_len;
        int push_pct;
        int pick;
        logic [DATA_WIDTH-1:0] val;
        logic [1:0] kind;

        // empty pops, extreme values, both ends
        add_req(REQ_POP_FRONT,  '0,           1'b0);
        add_req(REQ_POP_BACK,   '1,           1'b0);
        add_req(REQ_PUSH_FRONT, '1,           1'b0);
        add_req(REQ_PUSH_BACK,  '0,           1'b0);
        add_req(REQ_PUSH_FRONT, 32'hA5A5_5A5A, 1'b0);
        add_req(REQ_PUSH_BACK,  32'h8000_0001, 1'b0);
        add_req(REQ_POP_BACK,   32'h1234_5678, 1'b0);
        add_req(REQ_POP_FRONT,  '0,           1'b0);
        add_req(REQ_POP_FRONT,  '0,           1'b0);
        add_req(REQ_POP_BACK,   '0,           1'b0);
        add_req(REQ_POP_BACK,   '0,           1'b1);
        add_req(REQ_POP_FRONT,  '1,           1'b0);

        // bursts biased toward filling, draining or mixed traffic
        total = 0;
        while (total < RAND_ITEMS)
        begin
            mode     = $urandom_range(2);
            run_len  = $urandom_range(40, 6);
            push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int i = 0; i < run_len; i++)
            begin
                pick = $urandom_range(9);
                val  = (pick == 0) ? '1 : (pick == 1) ? '0 : $urandom;
                if ($urandom_range(99) < push_pct)
                    kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
                add_req(kind, val, $urandom_range(149) == 0);
                total++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
